// ===== design/cpms_pkg.sv =====
`timescale 1ns / 1ps
package cpms_pkg;

  localparam int CMD_W   = 1;
  localparam int IDX_W   = 6;
  localparam int PIXEL_W = 11;
  localparam int DIM_W   = 3;

  localparam int FRAME_COLUMNS_DEF = 44;
  localparam int SUBTICKS_DEF      = 8;
  localparam int LINE_COUNT_DEF    = 23;

  // Pixel 0 of pair 0 is swapped between the two columns; keep the rest.
  localparam logic [PIXEL_W-1:0] SWAP_KEEP = PIXEL_W'(16'hfffe);
  localparam logic [DIM_W-1:0]   DIM_RESET = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  // One scan step reads both columns of a pair at once.
  typedef struct packed {
    logic [PIXEL_W-1:0] odd_col;
    logic [PIXEL_W-1:0] even_col;
  } pair_t;

endpackage

// ===== design/cpms_frame_store.sv =====
`timescale 1ns / 1ps
module cpms_frame_store #(
  parameter int PAIRS = cpms_pkg::FRAME_COLUMNS_DEF / 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [$clog2(PAIRS)-1:0]       wr_pair,
  input  logic                           wr_odd,
  input  logic [cpms_pkg::PIXEL_W-1:0]   wr_pixels,
  input  logic [$clog2(PAIRS)-1:0]       rd_pair,
  output cpms_pkg::pair_t                rd_data
);
  import cpms_pkg::*;

  pair_t mem_r [PAIRS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PAIRS; k++) begin
        mem_r[k] <= '0;
      end
    end else if (wr_en) begin
      if (wr_odd) begin
        mem_r[wr_pair].odd_col <= wr_pixels;
      end else begin
        mem_r[wr_pair].even_col <= wr_pixels;
      end
    end
  end

  assign rd_data = mem_r[rd_pair];

endmodule

// ===== design/cpms_line_gen.sv =====
`timescale 1ns / 1ps
module cpms_line_gen #(
  parameter int PAIRS      = cpms_pkg::FRAME_COLUMNS_DEF / 2,
  parameter int LINE_COUNT = cpms_pkg::LINE_COUNT_DEF
) (
  input  logic [$clog2(PAIRS)-1:0] pair_idx,
  input  cpms_pkg::pair_t          pair_data,
  output logic [LINE_COUNT-1:0]    drive,
  output logic [LINE_COUNT-1:0]    high
);
  import cpms_pkg::*;

  logic [PIXEL_W-1:0] col_a;
  logic [PIXEL_W-1:0] col_b;

  // Pair 0 swaps pixel 0 between its columns.
  always_comb begin
    if (pair_idx == '0) begin
      col_a = (pair_data.even_col & SWAP_KEEP) | {{(PIXEL_W-1){1'b0}}, pair_data.odd_col[0]};
      col_b = (pair_data.odd_col & SWAP_KEEP) | {{(PIXEL_W-1){1'b0}}, pair_data.even_col[0]};
    end else begin
      col_a = pair_data.even_col;
      col_b = pair_data.odd_col;
    end
  end

  // Row line goes high; lines after it shift down one slot.
  always_comb begin
    int slot;
    int row;
    drive = '0;
    high  = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      slot = (i > int'(pair_idx)) ? i - 1 : i;
      row  = slot / 2;
      if (i == int'(pair_idx)) begin
        drive[i] = 1'b1;
        high[i]  = 1'b1;
      end else if (row < PIXEL_W) begin
        drive[i] = slot[0] ? col_b[row] : col_a[row];
      end
    end
  end

endmodule

// ===== design/charlieplex_matrix_scan.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports                                       | Transfer when
// in      | input     | in_command, in_column_index, in_column_pixels | in_valid & in_ready
// out     | output    | out_drive_mask, out_high_mask               | out_valid & out_ready
// cfg     | input     | cfg_dim_level                               | cfg_valid & cfg_ready
//
// One item per cycle: an input register feeds a single pass of pair lookup,
// line mapping and release/merge, which lands in the line state register.
// Writes produce no result and never stall; a tick holds in the input
// register while the previous result has not been taken.
// Synchronous active-low reset clears the frame store, counters and lines.
module charlieplex_matrix_scan #(
  parameter int FRAME_COLUMNS = cpms_pkg::FRAME_COLUMNS_DEF,
  parameter int SUBTICKS      = cpms_pkg::SUBTICKS_DEF,
  parameter int LINE_COUNT    = cpms_pkg::LINE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cpms_pkg::CMD_W-1:0]   in_command,
  input  logic [cpms_pkg::IDX_W-1:0]   in_column_index,
  input  logic [cpms_pkg::PIXEL_W-1:0] in_column_pixels,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LINE_COUNT-1:0]        out_drive_mask,
  output logic [LINE_COUNT-1:0]        out_high_mask,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cpms_pkg::DIM_W-1:0]   cfg_dim_level
);
  import cpms_pkg::*;

  localparam int PAIRS = FRAME_COLUMNS / 2;
  localparam int PW    = $clog2(PAIRS);
  localparam int SW    = (SUBTICKS > 1) ? $clog2(SUBTICKS) : 1;
  localparam int CMP_W = (SW > DIM_W) ? SW : DIM_W;
  localparam int STORED_COLS = 2 * PAIRS;

  // Input register
  logic               s1_valid_r;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [PIXEL_W-1:0] s1_pix_r;

  // Scan state
  logic [DIM_W-1:0]      dim_level_r;
  logic [PW-1:0]         scan_r;
  logic [SW-1:0]         sub_r;
  logic [LINE_COUNT-1:0] lit_drive_r;
  logic [LINE_COUNT-1:0] lit_high_r;
  logic [LINE_COUNT-1:0] line_drive_r;
  logic [LINE_COUNT-1:0] line_high_r;
  logic                  out_valid_r;

  logic                  s1_tick;
  logic                  advance;
  logic                  tick_go;
  logic                  wr_go;
  pair_t                 pair_data;
  logic [LINE_COUNT-1:0] scan_drive;
  logic [LINE_COUNT-1:0] scan_high;
  logic                  do_release;
  logic                  do_scan;
  logic [LINE_COUNT-1:0] base_drive;
  logic [LINE_COUNT-1:0] base_high;
  logic [LINE_COUNT-1:0] line_drive_nxt;
  logic [LINE_COUNT-1:0] line_high_nxt;
  logic [PW-1:0]         scan_nxt;
  logic [SW-1:0]         sub_nxt;

  assign s1_tick = (s1_cmd_r == CMD_TICK);
  // A write retires at once; a tick needs room in the result register.
  assign advance = s1_valid_r && (!s1_tick || !out_valid_r || out_ready);
  assign tick_go = advance && s1_tick;
  assign wr_go   = advance && !s1_tick && (int'(s1_idx_r) < STORED_COLS);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r <= in_command;
      s1_idx_r <= in_column_index;
      s1_pix_r <= in_column_pixels;
    end
  end

  cpms_frame_store #(
    .PAIRS (PAIRS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_go),
    .wr_pair   (PW'(s1_idx_r >> 1)),
    .wr_odd    (s1_idx_r[0]),
    .wr_pixels (s1_pix_r),
    .rd_pair   (scan_r),
    .rd_data   (pair_data)
  );

  cpms_line_gen #(
    .PAIRS      (PAIRS),
    .LINE_COUNT (LINE_COUNT)
  ) u_lines (
    .pair_idx  (scan_r),
    .pair_data (pair_data),
    .drive     (scan_drive),
    .high      (scan_high)
  );

  // Release first when the count meets the dim level, then merge a new scan.
  assign do_release = (CMP_W'(sub_r) == CMP_W'(dim_level_r));
  assign do_scan    = (sub_r == '0);

  always_comb begin
    base_drive = do_release ? (line_drive_r & ~lit_drive_r) : line_drive_r;
    base_high  = do_release ? (line_high_r & ~lit_high_r) : line_high_r;
    if (do_scan) begin
      line_drive_nxt = base_drive | scan_drive;
      line_high_nxt  = base_high | scan_high;
      scan_nxt       = (scan_r == PW'(PAIRS - 1)) ? '0 : scan_r + 1'b1;
      sub_nxt        = SW'(SUBTICKS - 1);
    end else begin
      line_drive_nxt = base_drive;
      line_high_nxt  = base_high;
      scan_nxt       = scan_r;
      sub_nxt        = sub_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r       <= '0;
      sub_r        <= '0;
      lit_drive_r  <= '0;
      lit_high_r   <= '0;
      line_drive_r <= '0;
      line_high_r  <= '0;
    end else if (tick_go) begin
      scan_r       <= scan_nxt;
      sub_r        <= sub_nxt;
      line_drive_r <= line_drive_nxt;
      line_high_r  <= line_high_nxt;
      if (do_scan) begin
        lit_drive_r <= scan_drive;
        lit_high_r  <= scan_high;
      end
    end
  end

  // Result valid: set by a tick, drop on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_level_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dim_level_r <= cfg_dim_level;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_mask = line_drive_r;
  assign out_high_mask  = line_high_r;

endmodule

// ===== tb/charlieplex_matrix_scan_test.sv =====
`timescale 1ns / 1ps
module charlieplex_matrix_scan_test;
  import cpms_pkg::*;

  localparam int LINES    = LINE_COUNT_DEF;
  localparam int COLUMNS  = FRAME_COLUMNS_DEF;
  localparam int PAIRS    = FRAME_COLUMNS_DEF / 2;
  localparam int SUBTICKS = SUBTICKS_DEF;
  // Input register plus line state register; leave margin for a write in flight.
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic [LINES-1:0] drive;
    logic [LINES-1:0] high;
  } line_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cmd_t                 in_command = CMD_WRITE;
  logic [IDX_W-1:0]     in_column_index = '0;
  logic [PIXEL_W-1:0]   in_column_pixels = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LINES-1:0]     out_drive_mask;
  logic [LINES-1:0]     out_high_mask;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [DIM_W-1:0]     cfg_dim_level = DIM_RESET;

  // Shadow copy of the scanner: frame, counters and line state.
  logic [PIXEL_W-1:0]   frame_copy [COLUMNS];
  int                   scan_pair;
  logic [DIM_W-1:0]     sub_count;
  logic [DIM_W-1:0]     dim_copy;
  logic [LINES-1:0]     lit_drive;
  logic [LINES-1:0]     lit_high;
  logic [LINES-1:0]     line_drive;
  logic [LINES-1:0]     line_high;

  line_state_t          pending_lines [$];
  bit                   quiet = 1'b0;
  int                   errors = 0;
  int                   transfers_in = 0;
  int                   lines_checked = 0;
  int                   dim_writes = 0;

  charlieplex_matrix_scan i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_column_index  (in_column_index),
    .in_column_pixels (in_column_pixels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_mask   (out_drive_mask),
    .out_high_mask    (out_high_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_dim_level    (cfg_dim_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("charlieplex_matrix_scan: mismatch");
    $finish;
  end

  // Stall the result side at random, except during the quiet stretch.
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 38);
  end

  // Lines lit by one scan step: the row line of the pair plus every column
  // line whose pixel is set. Pair 0 trades pixel 0 between its two columns.
  function automatic logic [LINES-1:0] pair_drive(int pair);
    logic [PIXEL_W-1:0] even_px;
    logic [PIXEL_W-1:0] odd_px;
    logic [PIXEL_W-1:0] even_orig;
    logic [LINES-1:0]   d;
    int                 slot;
    int                 row;
    even_px = frame_copy[2 * pair];
    odd_px  = frame_copy[2 * pair + 1];
    if (pair == 0) begin
      even_orig = even_px;
      even_px = (even_px & SWAP_KEEP) | {{(PIXEL_W-1){1'b0}}, odd_px[0]};
      odd_px  = (odd_px & SWAP_KEEP) | {{(PIXEL_W-1){1'b0}}, even_orig[0]};
    end
    d = '0;
    slot = 0;
    for (int i = 0; i < LINES; i++) begin
      if (i == pair) begin
        d[i] = 1'b1;
      end else begin
        // Odd slots come from the odd column, even slots from the even one;
        // slots past the last row stay dark.
        row = slot / 2;
        if (row < PIXEL_W) begin
          d[i] = (slot % 2) ? odd_px[row] : even_px[row];
        end
        slot++;
      end
    end
    return d;
  endfunction

  // Apply one accepted item to the shadow state; a tick queues the line state.
  task automatic predict_lines(cmd_t cmd, logic [IDX_W-1:0] idx, logic [PIXEL_W-1:0] pix);
    line_state_t      next_lines;
    logic [LINES-1:0] d;
    logic [LINES-1:0] h;
    if (cmd == CMD_WRITE) begin
      // Drop writes past the last column.
      if (idx < COLUMNS) begin
        frame_copy[idx] = pix;
      end
      return;
    end
    // Release first, so a scan in the same tick survives.
    if (sub_count == dim_copy) begin
      line_drive &= ~lit_drive;
      line_high  &= ~lit_high;
    end
    if (sub_count == 0) begin
      d = pair_drive(scan_pair);
      h = LINES'(1) << scan_pair;
      line_drive |= d;
      line_high  |= h;
      lit_drive = d;
      lit_high  = h;
      scan_pair = (scan_pair == PAIRS - 1) ? 0 : scan_pair + 1;
      sub_count = DIM_W'(SUBTICKS - 1);
    end else begin
      sub_count--;
    end
    next_lines.drive = line_drive;
    next_lines.high  = line_high;
    pending_lines.push_back(next_lines);
  endtask

  // Compare every result transfer against the oldest queued line state.
  always @(posedge clk) begin
    line_state_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected result drive %h high %h", $time,
                 out_drive_mask, out_high_mask);
      end else begin
        want = pending_lines.pop_front();
        lines_checked++;
        if (out_drive_mask !== want.drive) begin
          errors++;
          $display("%0t: drive_mask expected %h actual %h", $time, want.drive, out_drive_mask);
        end
        if (out_high_mask !== want.high) begin
          errors++;
          $display("%0t: high_mask expected %h actual %h", $time, want.high, out_high_mask);
        end
      end
    end
  end

  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < 38);
  endfunction

  // Enter and leave on a falling edge; hold valid and payload until transfer.
  // Each cycle before the item idles on its own draw.
  task automatic send_item(cmd_t cmd, logic [IDX_W-1:0] idx, logic [PIXEL_W-1:0] pix);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_column_index  <= idx;
    in_column_pixels <= pix;
    do @(posedge clk); while (!in_ready);
    predict_lines(cmd, idx, pix);
    transfers_in++;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [IDX_W-1:0]   idx;
    logic [PIXEL_W-1:0] pix;
    int                 roll;
    roll = $urandom_range(99);
    idx  = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(COLUMNS, 63))
                                    : IDX_W'($urandom_range(0, COLUMNS - 1));
    case ($urandom_range(7))
      0:       pix = '0;
      1:       pix = '1;
      default: pix = PIXEL_W'($urandom_range(0, 2047));
    endcase
    // Lean toward ticks so the scan sweeps the whole frame.
    send_item((roll < 55) ? CMD_TICK : CMD_WRITE, idx, pix);
  endtask

  // Change the dim level only with nothing in flight.
  task automatic set_dim(logic [DIM_W-1:0] level);
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_dim_level <= level;
    do @(posedge clk); while (!cfg_ready);
    dim_copy = level;
    dim_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_columns();
    // Edge patterns: pixel 0 trade on pair 0, full and empty columns,
    // the last pair, and writes past the frame that must be dropped.
    send_item(CMD_WRITE, 6'd0,  11'h001);
    send_item(CMD_WRITE, 6'd1,  11'h7fe);
    send_item(CMD_WRITE, 6'd2,  11'h7ff);
    send_item(CMD_WRITE, 6'd3,  11'h000);
    send_item(CMD_WRITE, 6'd42, 11'h555);
    send_item(CMD_WRITE, 6'd43, 11'h2aa);
    send_item(CMD_WRITE, 6'd44, 11'h7ff);
    send_item(CMD_WRITE, 6'd63, 11'h7ff);
    // Scan pair 0 and pair 1 with the reset dim level.
    repeat (9) send_item(CMD_TICK, 6'd0, 11'h000);
  endtask

  task automatic test_release_with_scan();
    // Dim level 0: release and rescan land on the same tick.
    set_dim(3'd0);
    repeat (8) send_item(CMD_TICK, 6'd63, 11'h7ff);
  endtask

  task automatic test_dim_sweep();
    logic [DIM_W-1:0] levels [8] = '{3'd7, 3'd0, 3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4};
    foreach (levels[k]) begin
      set_dim(levels[k]);
      repeat (50) send_random_item();
    end
  endtask

  task automatic test_back_to_back();
    // Full rate on both sides.
    quiet = 1'b1;
    repeat (100) send_random_item();
    quiet = 1'b0;
  endtask

  initial begin
    int wait_cycles;
    foreach (frame_copy[c]) frame_copy[c] = '0;
    scan_pair  = 0;
    sub_count  = '0;
    dim_copy   = DIM_RESET;
    lit_drive  = '0;
    lit_high   = '0;
    line_drive = '0;
    line_high  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_columns();
    test_release_with_scan();
    test_dim_sweep();
    test_back_to_back();

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_lines.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (pending_lines.size() != 0) begin
      errors++;
      $display("%0t: %0d line states never arrived", $time, pending_lines.size());
    end

    $display("covered %0d input transfers and %0d dim level writes,", transfers_in, dim_writes);
    $display("checked %0d line states across repeated full frame sweeps", lines_checked);
    if (errors == 0) begin
      $display("charlieplex_matrix_scan: match");
    end else begin
      $display("charlieplex_matrix_scan: mismatch");
    end
    $finish;
  end

endmodule
